FILE: hdl/sfrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_pkg
// Constants and result type shared by the sync frame receiver modules.
// ----------------------------------------------------------------------------
package sfrc_pkg;

    localparam logic [7:0] SYNC_FIRST     = 8'h7E;
    localparam logic [7:0] SYNC_SECOND    = 8'h02;
    localparam logic [7:0] SUM_COMPLEMENT = 8'hFF;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  frame_address;
        logic [31:0] frame_payload;
        logic        checksum_good;
    } frame_result_t;

endpackage

FILE: hdl/sfrc_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_frame_fsm
// Input byte register, frame position tracking, field capture and checksum.
// ----------------------------------------------------------------------------
module sfrc_frame_fsm (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    output logic                   res_valid,
    input  logic                   res_ready,
    output sfrc_pkg::frame_result_t res_data
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SYNC1 = 9'b000000010,
        ST_TYPE  = 9'b000000100,
        ST_ADDR  = 9'b000001000,
        ST_PAY0  = 9'b000010000,
        ST_PAY1  = 9'b000100000,
        ST_PAY2  = 9'b001000000,
        ST_PAY3  = 9'b010000000,
        ST_CHECK = 9'b100000000
    } frame_state_t;

    frame_state_t state_reg, state_next;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  addr_reg, addr_next;
    logic [31:0] payload_reg, payload_next;
    logic        adv;

    assign res_valid = in_valid_reg && (state_reg == ST_CHECK);
    assign adv       = in_valid_reg && ((state_reg != ST_CHECK) || res_ready);
    assign s_ready   = !in_valid_reg || adv;

    assign res_data = {type_reg, addr_reg, payload_reg,
                       ((sfrc_pkg::SUM_COMPLEMENT - sum_reg) == in_byte_reg)};

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next   = state_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        addr_next    = addr_reg;
        payload_next = payload_reg;
        if (adv) begin
            unique case (state_reg)
                ST_IDLE: begin
                    state_next = (in_byte_reg == sfrc_pkg::SYNC_FIRST) ? ST_SYNC1 : ST_IDLE;
                end
                ST_SYNC1: begin
                    if (in_byte_reg == sfrc_pkg::SYNC_SECOND) begin
                        sum_next   = sfrc_pkg::SYNC_SECOND;
                        state_next = ST_TYPE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
                ST_TYPE: begin
                    type_next  = in_byte_reg;
                    sum_next   = sum_reg + in_byte_reg;
                    state_next = ST_ADDR;
                end
                ST_ADDR: begin
                    addr_next  = in_byte_reg;
                    sum_next   = sum_reg + in_byte_reg;
                    state_next = ST_PAY0;
                end
                ST_PAY0, ST_PAY1, ST_PAY2, ST_PAY3: begin
                    payload_next = {payload_reg[23:0], in_byte_reg};
                    sum_next     = sum_reg + in_byte_reg;
                    unique case (state_reg)
                        ST_PAY0: state_next = ST_PAY1;
                        ST_PAY1: state_next = ST_PAY2;
                        ST_PAY2: state_next = ST_PAY3;
                        default: state_next = ST_CHECK;
                    endcase
                end
                ST_CHECK: begin
                    state_next = ST_IDLE;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_valid_reg <= 1'b0;
            sum_reg      <= '0;
            type_reg     <= '0;
            addr_reg     <= '0;
            payload_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            in_valid_reg <= in_valid_next;
            sum_reg      <= sum_next;
            type_reg     <= type_next;
            addr_reg     <= addr_next;
            payload_reg  <= payload_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
    end

    // bad second sync returns to hunting, byte not rechecked
    a_bad_sync2: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (state_reg == ST_SYNC1) && (in_byte_reg != sfrc_pkg::SYNC_SECOND))
        |=> (state_reg == ST_IDLE))
        else $error("bad second sync not dropped");

    a_sum_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (state_reg == ST_SYNC1) && (in_byte_reg == sfrc_pkg::SYNC_SECOND))
        |=> (sum_reg == sfrc_pkg::SYNC_SECOND) && (state_reg == ST_TYPE))
        else $error("checksum not seeded by second sync");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && (state_reg == ST_CHECK)) |=> (state_reg == ST_IDLE))
        else $error("frame not closed after checksum byte");

    a_check_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (state_reg == ST_CHECK) && in_valid_reg)
        else $error("checksum byte lost while result stalled");

endmodule

FILE: hdl/sfrc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_out_reg
// Result register holding a completed frame until the transaction completes.
// ----------------------------------------------------------------------------
module sfrc_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   res_valid,
    output logic                   res_ready,
    input  sfrc_pkg::frame_result_t res_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sfrc_pkg::frame_result_t m_data
);

    logic                    valid_reg, valid_next;
    sfrc_pkg::frame_result_t data_reg, data_next;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_data    = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_valid && res_ready) begin
            valid_next = 1'b1;
            data_next  = res_data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

FILE: hdl/sync_frame_receiver_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_checksum
// Assembles 9-byte sync frames from received bytes and checks the sum.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction, one per clock cycle when the
// result side keeps up. Bytes go through an input register and the frame
// logic; the output register loads a result as its checksum byte leaves
// the input register. Frames are 7E 02 type addr p0 p1 p2 p3 csum,
// with csum = FF - (02 + type + addr + p0..p3) mod 256; every complete frame
// gives one result, with checksum_good cleared on a mismatch. Only a checksum
// byte waits on the result side, and only while the output register is full.
module sync_frame_receiver_checksum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_type,
    output logic [7:0]  m_frame_address,
    output logic [31:0] m_frame_payload,
    output logic        m_checksum_good
);

    logic                    res_valid;
    logic                    res_ready;
    sfrc_pkg::frame_result_t res_data;
    sfrc_pkg::frame_result_t m_data;

    sfrc_frame_fsm u_frame_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    sfrc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_frame_type    = m_data.frame_type;
    assign m_frame_address = m_data.frame_address;
    assign m_frame_payload = m_data.frame_payload;
    assign m_checksum_good = m_data.checksum_good;

endmodule
